@@ hw/rtl/ccpr_pkg.sv @@
// Shared constants, status codes and the CRC-32 byte step for the
// CRC-checked packet receiver. No dependencies.
package ccpr_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 512;
    localparam int PAYLOAD_OFFSET      = 12;
    localparam int HEADER_LEN          = 8;
    localparam int CRC_LEN             = 4;

    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

    localparam logic [1:0] TYPE_OK    = 2'b01;
    localparam logic [9:0] LEN_SAT    = 10'd1023;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TYPE     = 3'd1;
    localparam logic [2:0] ST_TRUNC    = 3'd2;
    localparam logic [2:0] ST_SEQ      = 3'd3;
    localparam logic [2:0] ST_HDR_CRC  = 3'd4;
    localparam logic [2:0] ST_PAY_CRC  = 3'd5;
    localparam logic [2:0] ST_SHORT    = 3'd6;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/ccpr_ifs.sv @@
// Stream interfaces for the receiver: byte input and result output.
// Depends on nothing.
interface ccpr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ccpr_out_if;
    logic       valid;
    logic       ready;
    logic       is_status;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic [9:0] payload_length;

    modport source (output valid, output is_status, output payload_byte,
                    output status, output payload_length, input ready);
    modport sink   (input valid, input is_status, input payload_byte,
                    input status, input payload_length, output ready);
endinterface

@@ hw/rtl/crc_checked_packet_receiver.sv @@
// Top level of the CRC-checked packet receiver: header checks, CRC-32 checks,
// payload pass-through. Depends on ccpr_pkg and the interfaces in ccpr_ifs.sv.
//
//  channel   dir  contents
//  rx        in   data_byte[7:0], last_byte
//  tx        out  is_status, payload_byte[7:0], status[2:0], payload_length[9:0]
//  cfg       in   expected_seq_we, expected_seq_wdata[7:0]
//
// One word per cycle sustained while tx is not stalled; a word passes from rx
// to tx through the input register, then the result register. The CRC byte step
// between them sets the path. Reset clears all datagram state and expected_seq.
// A stalled tx holds its word; rx keeps flowing while the result register
// is free or being emptied.
module crc_checked_packet_receiver
    import ccpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
)(
    input  logic             clk,
    input  logic             rst_n,
    ccpr_in_if.sink          rx,
    ccpr_out_if.source       tx,
    input  logic             expected_seq_we,
    input  logic [7:0]       expected_seq_wdata
);

    localparam int POS_CAP = PAYLOAD_OFFSET + MAX_PAYLOAD + CRC_LEN;
    localparam int POS_W   = $clog2(POS_CAP + 1);
    localparam int SUM_W   = 17;

    // input stage
    logic       in_v_reg;
    logic [7:0] in_b_reg;
    logic       in_last_reg;

    // datagram state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      hdr_crc_reg, hdr_crc_next;
    logic [31:0]      rx_crc_reg, rx_crc_next;
    logic [15:0]      len_reg, len_next;
    logic [2:0]       err_reg, err_next;
    logic [7:0]       seq_reg;

    // result register
    logic       out_v_reg;
    logic       out_st_flag_reg;
    logic [7:0] out_byte_reg;
    logic [2:0] out_status_reg;
    logic [9:0] out_len_reg;

    logic       advance;
    logic       pass;
    logic [2:0] verdict;
    logic [SUM_W-1:0] pos_ext, len_ext, pay_end, crc_end, tail_min;
    logic       len_ok;
    logic [31:0] crc_step;

    assign advance  = in_v_reg && (!out_v_reg || tx.ready);
    assign rx.ready = !in_v_reg || advance;

    assign pos_ext  = SUM_W'(pos_reg);
    assign len_ext  = SUM_W'(len_reg);
    assign pay_end  = len_ext + SUM_W'(PAYLOAD_OFFSET);
    assign crc_end  = len_ext + SUM_W'(PAYLOAD_OFFSET + CRC_LEN);
    assign tail_min = len_ext + SUM_W'(PAYLOAD_OFFSET + CRC_LEN - 1);
    assign len_ok   = len_ext <= SUM_W'(MAX_PAYLOAD);
    assign crc_step = crc32_byte(crc_reg, in_b_reg);

    always_comb
    begin
        len_next     = len_reg;
        crc_next     = crc_reg;
        hdr_crc_next = hdr_crc_reg;
        rx_crc_next  = rx_crc_reg;
        err_next     = err_reg;
        pass         = 1'b0;

        if (pos_reg == POS_W'(0))
        begin
            if (in_b_reg[7:6] != TYPE_OK)
                err_next = (err_reg == ST_OK) ? ST_TYPE : err_reg;
            else if (in_b_reg[5])
                err_next = (err_reg == ST_OK) ? ST_TRUNC : err_reg;
        end
        else if (pos_reg == POS_W'(1))
        begin
            if (in_b_reg != seq_reg)
                err_next = (err_reg == ST_OK) ? ST_SEQ : err_reg;
        end
        else if (pos_reg == POS_W'(2))
            len_next = {in_b_reg, 8'd0};
        else if (pos_reg == POS_W'(3))
            len_next = {len_reg[15:8], in_b_reg};

        if (pos_ext < SUM_W'(HEADER_LEN))
        begin
            crc_next = crc_step;
            if (pos_reg == POS_W'(HEADER_LEN - 1))
            begin
                hdr_crc_next = ~crc_step;
                crc_next     = CRC_PRESET;
            end
        end
        else if (pos_ext < SUM_W'(PAYLOAD_OFFSET))
        begin
            rx_crc_next = {rx_crc_reg[23:0], in_b_reg};
            if (pos_reg == POS_W'(PAYLOAD_OFFSET - 1) && rx_crc_next != hdr_crc_reg)
                err_next = (err_reg == ST_OK) ? ST_HDR_CRC : err_reg;
        end
        else if (len_ok)
        begin
            if (pos_ext < pay_end)
            begin
                crc_next = crc_step;
                pass     = 1'b1;
            end
            else if (pos_ext < crc_end)
                rx_crc_next = {rx_crc_reg[23:0], in_b_reg};
        end

        pos_next = (pos_ext < SUM_W'(POS_CAP)) ? pos_reg + POS_W'(1) : pos_reg;

        // header-short datagrams fail before length matters
        if (err_next != ST_OK)
            verdict = err_next;
        else if (pos_ext < SUM_W'(PAYLOAD_OFFSET - 1))
            verdict = ST_SHORT;
        else if (!len_ok || pos_ext < tail_min)
            verdict = ST_SHORT;
        else if (rx_crc_next != ~crc_next)
            verdict = ST_PAY_CRC;
        else
            verdict = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
            seq_reg     <= 8'd0;
            pos_reg     <= '0;
            crc_reg     <= CRC_PRESET;
            hdr_crc_reg <= 32'd0;
            rx_crc_reg  <= 32'd0;
            len_reg     <= 16'd0;
            err_reg     <= ST_OK;
        end
        else
        begin
            if (expected_seq_we)
                seq_reg <= expected_seq_wdata;

            if (rx.ready)
                in_v_reg <= rx.valid;

            if (advance && (in_last_reg || pass))
                out_v_reg <= 1'b1;
            else if (tx.ready)
                out_v_reg <= 1'b0;

            if (advance)
            begin
                if (in_last_reg)
                begin
                    pos_reg     <= '0;
                    crc_reg     <= CRC_PRESET;
                    hdr_crc_reg <= 32'd0;
                    rx_crc_reg  <= 32'd0;
                    len_reg     <= 16'd0;
                    err_reg     <= ST_OK;
                end
                else
                begin
                    pos_reg     <= pos_next;
                    crc_reg     <= crc_next;
                    hdr_crc_reg <= hdr_crc_next;
                    rx_crc_reg  <= rx_crc_next;
                    len_reg     <= len_next;
                    err_reg     <= err_next;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_b_reg    <= rx.data_byte;
            in_last_reg <= rx.last_byte;
        end

        if (advance && (in_last_reg || pass))
        begin
            out_st_flag_reg <= in_last_reg;
            out_byte_reg    <= in_last_reg ? 8'd0 : in_b_reg;
            out_status_reg  <= in_last_reg ? verdict : ST_OK;
            if (!in_last_reg)
                out_len_reg <= 10'd0;
            else if (len_next > 16'(LEN_SAT))
                out_len_reg <= LEN_SAT;
            else
                out_len_reg <= len_next[9:0];
        end
    end

    assign tx.valid          = out_v_reg;
    assign tx.is_status      = out_st_flag_reg;
    assign tx.payload_byte   = out_byte_reg;
    assign tx.status         = out_status_reg;
    assign tx.payload_length = out_len_reg;

`ifndef ASSERT_OFF
    a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> pos_reg == '0 && err_reg == ST_OK)
        else $error("datagram state not cleared after verdict");

    a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(pos_reg) <= SUM_W'(POS_CAP))
        else $error("byte position past cap");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && !tx.is_status |-> tx.status == ST_OK && tx.payload_length == 10'd0)
        else $error("payload word carries status fields");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.is_status |-> tx.status <= ST_SHORT && tx.payload_byte == 8'd0)
        else $error("bad verdict word");
`endif

endmodule
